/* hdl/a64dp_pkg.sv */
// a64dp_pkg: shared types and encoding constants for the A64 data-processing
// execute block. No dependencies.

package a64dp_pkg;

  localparam int XLEN       = 64;
  localparam int INSTR_W    = 32;
  localparam int REG_COUNT  = 31;
  localparam int REG_AW     = 5;
  localparam int OPND_COUNT = 3;
  localparam int HALF_BITS  = 16;

  typedef logic [XLEN-1:0]   xword_t;
  typedef logic [REG_AW-1:0] reg_idx_t;

  localparam reg_idx_t    ZERO_REG  = 5'b11111;
  localparam logic [15:0] HALF_MASK = 16'hFFFF;

  // immediate group, bits 25:23
  localparam logic [2:0] OPI_ADDSUB   = 3'd2;
  localparam logic [2:0] OPI_MOVEWIDE = 3'd5;

  // wide move opc
  localparam logic [1:0] OPC_MOVN     = 2'd0;
  localparam logic [1:0] OPC_MOVE_RSV = 2'd1;
  localparam logic [1:0] OPC_MOVZ     = 2'd2;

  // logical opc
  localparam logic [1:0] OPC_ORR  = 2'd1;
  localparam logic [1:0] OPC_EOR  = 2'd2;
  localparam logic [1:0] OPC_ANDS = 2'd3;

  // multiply: opc and opr fields
  localparam logic [1:0] OPC_MADD = 2'd0;
  localparam logic [3:0] OPR_MUL  = 4'b1000;

  // shift types
  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;
  localparam logic [1:0] SHIFT_ROR = 2'd3;

endpackage

/* hdl/a64dp_in_if.sv */
// a64dp_in_if: instruction channel (valid/ready plus instruction payload).
// Depends on a64dp_pkg.

interface a64dp_in_if
  import a64dp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instruction_word;
  logic               imm_form;

  modport source (output valid, instruction_word, imm_form, input ready);
  modport sink   (input valid, instruction_word, imm_form, output ready);
endinterface

/* hdl/a64dp_out_if.sv */
// a64dp_out_if: result channel (valid/ready plus result payload).
// Depends on a64dp_pkg.

interface a64dp_out_if
  import a64dp_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       reg_written;
  reg_idx_t   dest_reg;
  xword_t     written_value;
  logic [3:0] flags_nzcv;
  logic       unhandled;

  modport source (output valid, reg_written, dest_reg, written_value, flags_nzcv, unhandled,
                  input ready);
  modport sink   (input valid, reg_written, dest_reg, written_value, flags_nzcv, unhandled,
                  output ready);
endinterface

/* hdl/a64dp_ram.sv */
// a64dp_ram: generic single-write, single-read RAM with registered read.
// No dependencies.

module a64dp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/a64_data_processing_execute.sv */
// a64_data_processing_execute: A64 integer data-processing execute stage.
// Depends on a64dp_pkg, a64dp_in_if, a64dp_out_if and a64dp_ram.

// Executes one A64 data-processing instruction per beat: add/sub (immediate or
// shifted register, with or without flags), the logical group, movn/movz/movk and
// madd/msub, in 64- and 32-bit forms, against a 31 x 64-bit register file and the
// NZCV flags. Register 31 reads as zero and writes to it are dropped; stack-pointer
// uses and undefined encodings return unhandled with no register or flag update.
// Rate: one instruction per clock sustained unless the result channel stalls.
// The input beat loads stage 1 and starts the register read (RAM, registered);
// stage 1 (operand bypass, decode, add/logic/shift/move and the multiply partial
// products) loads stage 2, and stage 2 (multiply accumulate, register and flag
// write-back) loads the output register. The only bubble: an instruction whose rn,
// rm or ra/rd field names the destination of the multiply just ahead of it waits
// until that multiply leaves stage 2, as the product is only final in stage 2.
// The register file is three copies of one RAM (one read port each, for rn, rm and
// ra/rd); per-entry valid bits give zero after reset, so there is no clearing pass.
// Results are presented in instruction order, one per beat.

module a64_data_processing_execute
  import a64dp_pkg::*;
(
  input logic          clk,
  input logic          rst,
  a64dp_in_if.sink     instr,
  a64dp_out_if.source  result
);

  typedef struct packed {
    logic       reg_written;
    reg_idx_t   rd;
    xword_t     value;      // final result for everything but multiply
    logic       is_mul;
    logic       mul_sub;
    logic       w64;
    xword_t     acc;        // ra operand
    xword_t     pp_low;     // a_lo * b_lo
    logic [31:0] pp_lh;     // a_lo * b_hi, low half
    logic [31:0] pp_hl;     // a_hi * b_lo, low half
    logic       bad;
    logic       flag_set;
    logic [3:0] nzcv;
  } s2_t;

  // handshake
  logic in_beat, out_free, s1_adv, s2_adv, hazard;

  // stage 1
  logic         s1_valid;
  logic [31:0]  s1_word;
  logic         s1_imm;
  reg_idx_t     new_addr  [OPND_COUNT];
  reg_idx_t     s1_addr   [OPND_COUNT];
  xword_t       ram_rdata [OPND_COUNT];
  logic         rd_vbit   [OPND_COUNT];
  logic         ovr_vld   [OPND_COUNT];
  xword_t       ovr_val   [OPND_COUNT];
  logic         s2_hit    [OPND_COUNT];
  xword_t       opnd      [OPND_COUNT];
  s2_t          s2_next;

  // stage 2
  logic         s2_valid;
  s2_t          s2;
  xword_t       s2_value;

  // write-back
  logic                 wr_en;
  reg_idx_t             wr_addr;
  xword_t               wr_data;
  logic [REG_COUNT:0]   reg_valid;  // top bit is the zero register, never set
  logic [3:0]           flags;

  // shifter for the register forms; v is already masked to the operand width
  function automatic xword_t shift_operand(xword_t v, logic [1:0] kind, logic [5:0] amt,
                                           logic w64);
    xword_t       mask;
    xword_t       sext;
    logic [127:0] dup;
    logic [127:0] rot;
    xword_t       res;
    mask = w64 ? '1 : 64'h0000_0000_FFFF_FFFF;
    sext = w64 ? v : {{32{v[31]}}, v[31:0]};
    dup  = w64 ? {v, v} : {64'b0, v[31:0], v[31:0]};
    rot  = dup >> amt;
    case (kind)
      SHIFT_LSL: res = (v << amt) & mask;
      SHIFT_LSR: res = v >> amt;
      SHIFT_ASR: res = 64'($signed(sext) >>> amt) & mask;
      default:   res = rot[63:0] & mask;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- handshake
  assign out_free    = !result.valid || result.ready;
  assign s2_adv      = s2_valid && out_free;
  assign s1_adv      = s1_valid && !hazard && (!s2_valid || s2_adv);
  assign instr.ready = !s1_valid || s1_adv;
  assign in_beat     = instr.valid && instr.ready;

  // read addresses: rn, rm, and ra (register group) or rd (movk)
  assign new_addr[0] = instr.instruction_word[9:5];
  assign new_addr[1] = instr.instruction_word[20:16];
  assign new_addr[2] = instr.imm_form ? instr.instruction_word[4:0]
                                      : instr.instruction_word[14:10];
  assign s1_addr[0]  = s1_word[9:5];
  assign s1_addr[1]  = s1_word[20:16];
  assign s1_addr[2]  = s1_imm ? s1_word[4:0] : s1_word[14:10];

  // ---------------------------------------------------------------- register file
  for (genvar p = 0; p < OPND_COUNT; p++) begin : g_port
    a64dp_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (in_beat),
      .raddr (new_addr[p]),
      .rdata (ram_rdata[p])
    );

    // Catch writes the RAM read missed: one landing on the read edge, and any
    // landing while the instruction waits in stage 1.
    always_ff @(posedge clk) begin
      if (in_beat) begin
        rd_vbit[p] <= reg_valid[new_addr[p]];
        ovr_vld[p] <= wr_en && (wr_addr == new_addr[p]);
        if (wr_en && (wr_addr == new_addr[p])) begin
          ovr_val[p] <= wr_data;
        end
      end else if (wr_en && (wr_addr == s1_addr[p])) begin
        ovr_vld[p] <= 1'b1;
        ovr_val[p] <= wr_data;
      end
    end

    // stage 2 holds the youngest older result, so it wins
    assign s2_hit[p] = s2_valid && s2.reg_written && !s2.is_mul && (s2.rd == s1_addr[p]);

    always_comb begin
      xword_t raw;
      if (s2_hit[p]) begin
        raw = s2.value;
      end else if (ovr_vld[p]) begin
        raw = ovr_val[p];
      end else if (rd_vbit[p]) begin
        raw = ram_rdata[p];
      end else begin
        raw = '0;
      end
      opnd[p] = s1_word[31] ? raw : {32'b0, raw[31:0]};
    end
  end

  // multiply result is not ready until stage 2: hold a dependent instruction
  assign hazard = s1_valid && s2_valid && s2.reg_written && s2.is_mul &&
                  ((s2.rd == s1_addr[0]) || (s2.rd == s1_addr[1]) || (s2.rd == s1_addr[2]));

  // ---------------------------------------------------------------- stage 1 execute
  always_comb begin
    logic        w64;
    logic [1:0]  opc;
    reg_idx_t    rd;
    reg_idx_t    rn;
    logic [2:0]  opi;
    logic [3:0]  opr;
    logic [5:0]  imm6;
    logic [1:0]  hw;
    logic [5:0]  sh;
    xword_t      mask;
    xword_t      a;
    xword_t      b;
    xword_t      c;
    xword_t      shifted;
    xword_t      imm_op2;
    xword_t      as_b;
    xword_t      bb;
    logic [64:0] sum;
    xword_t      as_res;
    xword_t      ovf_vec;
    logic [3:0]  as_flags;
    xword_t      lop2;
    xword_t      log_res;
    xword_t      mop;
    xword_t      mov_res;
    logic        bad;

    w64   = s1_word[31];
    opc   = s1_word[30:29];
    rd    = s1_word[4:0];
    rn    = s1_word[9:5];
    opi   = s1_word[25:23];
    opr   = s1_word[24:21];
    imm6  = s1_word[15:10];
    hw    = s1_word[22:21];
    sh    = 6'(hw * HALF_BITS);
    mask  = w64 ? '1 : 64'h0000_0000_FFFF_FFFF;
    a     = opnd[0];
    b     = opnd[1];
    c     = opnd[2];

    // add / sub
    shifted  = shift_operand(b, opr[2:1], imm6, w64);
    imm_op2  = s1_word[22] ? {40'b0, s1_word[21:10], 12'b0} : {52'b0, s1_word[21:10]};
    as_b     = s1_imm ? imm_op2 : shifted;
    bb       = opc[1] ? (~as_b & mask) : (as_b & mask);
    sum      = {1'b0, a} + {1'b0, bb} + 65'(opc[1]);
    as_res   = w64 ? sum[63:0] : {32'b0, sum[31:0]};
    ovf_vec  = (a ^ as_res) & (bb ^ as_res);
    as_flags = {w64 ? as_res[63] : as_res[31], as_res == '0,
                w64 ? sum[64] : sum[32], w64 ? ovf_vec[63] : ovf_vec[31]};

    // logical
    lop2 = opr[0] ? (~shifted & mask) : shifted;
    case (opc)
      OPC_ORR: log_res = a | lop2;
      OPC_EOR: log_res = a ^ lop2;
      default: log_res = a & lop2;
    endcase

    // wide move
    mop = {48'b0, s1_word[20:5]} << sh;
    case (opc)
      OPC_MOVN: mov_res = ~mop & mask;
      OPC_MOVZ: mov_res = mop;
      default:  mov_res = ((c & ~({48'b0, HALF_MASK} << sh)) | mop) & mask;
    endcase

    bad              = 1'b0;
    s2_next.value    = '0;
    s2_next.is_mul   = 1'b0;
    s2_next.flag_set = 1'b0;
    s2_next.nzcv     = as_flags;

    if (s1_imm) begin
      case (opi)
        OPI_ADDSUB: begin
          if (rn == ZERO_REG || (rd == ZERO_REG && !opc[0])) begin
            bad = 1'b1;
          end else begin
            s2_next.value    = as_res;
            s2_next.flag_set = opc[0];
          end
        end
        OPI_MOVEWIDE: begin
          if (opc == OPC_MOVE_RSV || (!w64 && hw[1])) begin
            bad = 1'b1;
          end else begin
            s2_next.value = mov_res;
          end
        end
        default: bad = 1'b1;
      endcase
    end else if (s1_word[28]) begin
      if (opr != OPR_MUL || opc != OPC_MADD) begin
        bad = 1'b1;
      end else begin
        s2_next.is_mul = 1'b1;
      end
    end else if (!w64 && imm6[5]) begin
      bad = 1'b1;
    end else if (opr[3]) begin
      if (opr[0] || opr[2:1] == SHIFT_ROR || (rd == ZERO_REG && !opc[0])) begin
        bad = 1'b1;
      end else begin
        s2_next.value    = as_res;
        s2_next.flag_set = opc[0];
      end
    end else begin
      s2_next.value = log_res;
      if (opc == OPC_ANDS) begin
        s2_next.flag_set = 1'b1;
        s2_next.nzcv     = {w64 ? log_res[63] : log_res[31], log_res == '0, 2'b00};
      end
    end

    s2_next.bad         = bad;
    s2_next.reg_written = !bad && (rd != ZERO_REG);
    s2_next.rd          = rd;
    s2_next.mul_sub     = s1_word[15];
    s2_next.w64         = w64;
    s2_next.acc         = c;
    s2_next.pp_low      = 64'(a[31:0]) * 64'(b[31:0]);
    s2_next.pp_lh       = 32'(a[31:0] * b[63:32]);
    s2_next.pp_hl       = 32'(a[63:32] * b[31:0]);
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    xword_t prod;
    xword_t mul_val;
    prod     = s2.pp_low + {s2.pp_lh + s2.pp_hl, 32'b0};
    mul_val  = s2.mul_sub ? (s2.acc - prod) : (s2.acc + prod);
    mul_val  = s2.w64 ? mul_val : {32'b0, mul_val[31:0]};
    s2_value = s2.is_mul ? mul_val : s2.value;
  end

  assign wr_en   = s2_adv && s2.reg_written;
  assign wr_addr = s2.rd;
  assign wr_data = s2_value;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
      reg_valid    <= '0;
      flags        <= '0;
    end else begin
      if (in_beat) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end

      if (s2_adv) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end

      if (wr_en) begin
        reg_valid[wr_addr] <= 1'b1;
      end
      if (s2_adv && s2.flag_set) begin
        flags <= s2.nzcv;
      end
    end

    if (in_beat) begin
      s1_word <= instr.instruction_word;
      s1_imm  <= instr.imm_form;
    end
    if (s1_adv) begin
      s2 <= s2_next;
    end
    if (s2_adv) begin
      result.reg_written   <= s2.reg_written;
      result.dest_reg      <= s2.rd;
      result.written_value <= s2_value;
      result.flags_nzcv    <= s2.flag_set ? s2.nzcv : flags;
      result.unhandled     <= s2.bad;
    end
  end

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  a_hazard_src: assert property (@(posedge clk) disable iff (rst)
    hazard |-> s2_valid && s2.is_mul && !s1_adv)
    else $error("stall without a multiply ahead");

  a_unhandled: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.unhandled |-> !result.reg_written && result.written_value == '0)
    else $error("unhandled beat carries a write");

  a_zero_reg: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> wr_addr != ZERO_REG)
    else $error("write to zero register");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_word))
    else $error("stage 1 lost a held instruction");

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    s2_adv && !s2.flag_set |=> flags == $past(flags))
    else $error("flags changed by a non-flag-setting instruction");
`endif

endmodule
